// File: sv/gbn_pkg.sv
// Package for the Go-Back-N sender: shared constants, request codes and
// the request type of the shared adder. No dependencies.
package gbn_pkg;

    localparam int BUFFER_SIZE_DEF   = 1024;
    localparam int PAYLOAD_BYTES_DEF = 20;
    localparam int MAX_WINDOW        = 64;

    localparam int SUM_W    = 13;   // checksum width
    localparam int SEQ_W    = 10;   // sequence number port width
    localparam int PAY_W    = 160;  // payload port width (20 bytes)
    localparam int ACK_W    = 11;
    localparam int WIN_W    = 7;
    localparam int TMO_W    = 16;
    localparam int CFG_W    = 16;
    localparam int IN_W     = 176;  // input tdata, padded to bytes
    localparam int OUT_W    = 184;  // output tdata, padded to bytes

    localparam logic [WIN_W-1:0] WINDOW_RESET  = 7'd8;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd20;

    // request codes carried in tuser
    localparam logic [1:0] REQ_MSG  = 2'd0;
    localparam logic [1:0] REQ_ACK  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // configuration register indexes
    localparam logic REG_WINDOW  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
    } gbn_alu_req_t;

endpackage

// File: sv/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/gbn_alu.sv
// Shared checksum adder: byte accumulation while a message is stored,
// sequence number plus byte sum when a packet goes out. Uses gbn_pkg.
module gbn_alu import gbn_pkg::*; (
    input  gbn_alu_req_t     req,
    output logic [SUM_W-1:0] sum
);

    assign sum = req.a + req.b;

endmodule

// File: sv/go_back_n_sender_top.sv
// Go-Back-N ARQ sender top level; uses gbn_pkg, gbn_ram (message store), gbn_alu (adder).
// One item at a time: a stored message is scanned byte by byte, written to the store, then
// sent as far as the window allows; an ack or tick may open a send or resend run. Each packet
// is a store read, then a capture; a stalled result holds the run in capture. Reset clears
// window pointers, counters and timer and loads the config defaults; the store is not cleared,
// only written entries are read.
module go_back_n_sender_top import gbn_pkg::*; #(
    parameter int BUFFER_SIZE   = BUFFER_SIZE_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // input channel
    input  logic             s_tvalid,
    output logic             s_tready,
    // s_tdata fields from bit 0: payload_lo, payload_mid, payload_hi, ack_number
    input  logic [IN_W-1:0]  s_tdata,
    // s_tuser fields from bit 0: req_type
    input  logic [1:0]       s_tuser,
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    // m_tdata fields from bit 0: seq_number, packet_sum, out_payload_lo,
    // out_payload_mid, out_payload_hi
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,   // last_of_run
    // configuration
    input  logic             cfg_wr_en,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(BUFFER_SIZE);
    localparam int CW    = $clog2(BUFFER_SIZE + 1);
    localparam int PW    = PAYLOAD_BYTES * 8;
    localparam int KW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int LIM_W = ((CW > WIN_W) ? CW : WIN_W) + 1;
    localparam int MW    = PW + SUM_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MSG   = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_CAPT  = 5'b10000
    } state_t;

    // control state
    state_t           state_reg,   state_next;
    logic [CW-1:0]    base_reg,    base_next;
    logic [CW-1:0]    next_reg,    next_next;
    logic [CW-1:0]    stored_reg,  stored_next;
    logic             run_reg,     run_next;
    logic [TMO_W-1:0] left_reg,    left_next;
    logic [WIN_W-1:0] win_reg,     win_next;
    logic [TMO_W-1:0] tmo_reg,     tmo_next;
    logic [CW-1:0]    idx_reg,     idx_next;
    logic             resend_reg,  resend_next;
    logic             at_base_reg, at_base_next;
    logic             any_reg,     any_next;
    logic             ended_reg,   ended_next;
    logic [KW-1:0]    k_reg,       k_next;
    logic             mv_reg,      mv_next;

    // payload state
    logic [PW-1:0]    shift_reg,   shift_next;
    logic [SUM_W-1:0] acc_reg,     acc_next;
    logic [AW-1:0]    cur_reg,     cur_next;
    logic [SEQ_W-1:0] oseq_reg,    oseq_next;
    logic [SUM_W-1:0] osum_reg,    osum_next;
    logic [PAY_W-1:0] opay_reg,    opay_next;
    logic             olast_reg,   olast_next;

    // store and adder hookup
    logic             ram_we, ram_re;
    logic [MW-1:0]    ram_rdata;
    gbn_alu_req_t     alu_req;
    logic [SUM_W-1:0] alu_sum;

    // combinational helpers
    logic [WIN_W-1:0] eff_win;
    logic [TMO_W-1:0] eff_tmo;
    logic [LIM_W-1:0] limit;
    logic             more;
    logic [7:0]       cur_byte, kept_byte;
    logic             end_now;
    logic [PAY_W-1:0] in_pay;
    logic [ACK_W-1:0] ack;
    logic [CW-1:0]    base_inc;
    logic             ack_ok;
    logic             out_free;

    gbn_ram #(
        .WIDTH (MW),
        .DEPTH (BUFFER_SIZE)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (stored_reg[AW-1:0]),
        .wr_data ({acc_reg, shift_reg}),
        .rd_en   (ram_re),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    gbn_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    // window clamped to 1..MAX_WINDOW, timeout zero acts as one
    always_comb begin
        eff_win = win_reg;
        if (win_reg == '0) begin
            eff_win = WIN_W'(1);
        end else if (win_reg > WIN_W'(MAX_WINDOW)) begin
            eff_win = WIN_W'(MAX_WINDOW);
        end
    end
    assign eff_tmo = (tmo_reg == '0) ? TMO_W'(1) : tmo_reg;
    assign limit   = LIM_W'(base_reg) + LIM_W'(eff_win);

    // another packet to go at idx: resend runs to next-1, a fresh send
    // stops at the stored count or the window edge
    assign more = resend_reg ? (idx_reg < next_reg)
                             : ((idx_reg < stored_reg) && (LIM_W'(idx_reg) < limit));

    // byte scan: once a zero is seen the rest of the message is zero
    assign cur_byte  = shift_reg[7:0];
    assign end_now   = ended_reg || (cur_byte == 8'd0);
    assign kept_byte = end_now ? 8'd0 : cur_byte;

    assign in_pay   = s_tdata[PAY_W-1:0];
    assign ack      = s_tdata[PAY_W +: ACK_W];
    assign base_inc = base_reg + CW'(1);
    assign ack_ok   = !ack[ACK_W-1] && (ack == ACK_W'(base_reg)) && (base_reg < next_reg);
    assign out_free = !mv_reg || m_tready;

    // one adder: accumulate bytes during the scan, add the sequence number on send
    always_comb begin
        if (state_reg == ST_CAPT) begin
            alu_req.a = ram_rdata[PW +: SUM_W];
            alu_req.b = SUM_W'(cur_reg);
        end else begin
            alu_req.a = acc_reg;
            alu_req.b = SUM_W'(kept_byte);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign ram_we   = (state_reg == ST_WRITE);
    assign ram_re   = (state_reg == ST_CHECK) && more;

    always_comb begin
        state_next   = state_reg;
        base_next    = base_reg;
        next_next    = next_reg;
        stored_next  = stored_reg;
        run_next     = run_reg;
        left_next    = left_reg;
        win_next     = win_reg;
        tmo_next     = tmo_reg;
        idx_next     = idx_reg;
        resend_next  = resend_reg;
        at_base_next = at_base_reg;
        any_next     = any_reg;
        ended_next   = ended_reg;
        k_next       = k_reg;
        mv_next      = mv_reg;
        shift_next   = shift_reg;
        acc_next     = acc_reg;
        cur_next     = cur_reg;
        oseq_next    = oseq_reg;
        osum_next    = osum_reg;
        opay_next    = opay_reg;
        olast_next   = olast_reg;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WINDOW:  win_next = cfg_wdata[WIN_W-1:0];
                REG_TIMEOUT: tmo_next = cfg_wdata[TMO_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        REQ_MSG: begin
                            if (stored_reg < CW'(BUFFER_SIZE)) begin
                                shift_next = in_pay[PW-1:0];
                                acc_next   = '0;
                                ended_next = 1'b0;
                                k_next     = '0;
                                state_next = ST_MSG;
                            end
                        end
                        REQ_ACK: begin
                            if (ack_ok) begin
                                base_next = base_inc;
                                run_next  = 1'b0;
                                left_next = '0;
                                if (base_inc < next_reg) begin
                                    // others outstanding: restart timer only
                                    run_next  = 1'b1;
                                    left_next = eff_tmo;
                                end else begin
                                    idx_next     = next_reg;
                                    resend_next  = 1'b0;
                                    at_base_next = 1'b1;
                                    any_next     = 1'b0;
                                    state_next   = ST_CHECK;
                                end
                            end
                        end
                        REQ_TICK: begin
                            if (run_reg) begin
                                if (left_reg[TMO_W-1:1] == '0) begin
                                    // timeout: go back to base
                                    run_next    = 1'b0;
                                    left_next   = '0;
                                    idx_next    = base_reg;
                                    resend_next = 1'b1;
                                    any_next    = 1'b0;
                                    state_next  = ST_CHECK;
                                end else begin
                                    left_next = left_reg - TMO_W'(1);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MSG: begin
                shift_next = (shift_reg >> 8) | (PW'(kept_byte) << (PW - 8));
                acc_next   = alu_sum;
                ended_next = end_now;
                k_next     = k_reg + KW'(1);
                if (k_reg == KW'(PAYLOAD_BYTES - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                stored_next  = stored_reg + CW'(1);
                idx_next     = next_reg;
                resend_next  = 1'b0;
                at_base_next = (base_reg == next_reg);
                any_next     = 1'b0;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                if (more) begin
                    cur_next = idx_reg[AW-1:0];
                    idx_next = idx_reg + CW'(1);
                    if (!resend_reg) begin
                        next_next = idx_reg + CW'(1);
                    end
                    any_next   = 1'b1;
                    state_next = ST_CAPT;
                end else begin
                    if (any_reg && (resend_reg || at_base_reg)) begin
                        run_next  = 1'b1;
                        left_next = eff_tmo;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_CAPT: begin
                if (out_free) begin
                    oseq_next  = SEQ_W'(cur_reg);
                    osum_next  = alu_sum;
                    opay_next  = PAY_W'(ram_rdata[PW-1:0]);
                    olast_next = !more;
                    mv_next    = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            base_reg    <= '0;
            next_reg    <= '0;
            stored_reg  <= '0;
            run_reg     <= 1'b0;
            left_reg    <= '0;
            win_reg     <= WINDOW_RESET;
            tmo_reg     <= TIMEOUT_RESET;
            idx_reg     <= '0;
            resend_reg  <= 1'b0;
            at_base_reg <= 1'b0;
            any_reg     <= 1'b0;
            ended_reg   <= 1'b0;
            k_reg       <= '0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            next_reg    <= next_next;
            stored_reg  <= stored_next;
            run_reg     <= run_next;
            left_reg    <= left_next;
            win_reg     <= win_next;
            tmo_reg     <= tmo_next;
            idx_reg     <= idx_next;
            resend_reg  <= resend_next;
            at_base_reg <= at_base_next;
            any_reg     <= any_next;
            ended_reg   <= ended_next;
            k_reg       <= k_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        acc_reg   <= acc_next;
        cur_reg   <= cur_next;
        oseq_reg  <= oseq_next;
        osum_reg  <= osum_next;
        opay_reg  <= opay_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {1'b0, opay_reg, osum_reg, oseq_reg};
    assign m_tlast  = olast_reg;

`ifndef SYNTHESIS
    // window pointers stay ordered inside the stored range
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (base_reg <= next_reg) && (next_reg <= stored_reg))
        else $error("window pointers out of order");

    // never more than a full window outstanding
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (LIM_W'(next_reg) - LIM_W'(base_reg)) <= LIM_W'(MAX_WINDOW))
        else $error("outstanding packets exceed window");

    // a running timer always has ticks left
    a_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> (left_reg != '0))
        else $error("timer running with zero count");
`endif

endmodule

// File: dv/gbn_send_tracker_pkg.sv
// Packet predictor and in-order checker for the Go-Back-N sender bench.
// Depends on gbn_pkg for widths, request codes and register indexes.
package gbn_send_tracker_pkg;
    import gbn_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;  // not decoded by the block
    localparam int         MAX_PRINTED = 100;

    typedef struct {
        logic [SEQ_W-1:0] seq;
        logic [SUM_W-1:0] sum;
        logic [63:0]      lo;
        logic [63:0]      mid;
        logic [31:0]      hi;
        logic             last;
    } gbn_packet_t;

    class gbn_send_tracker;
        logic [PAY_W-1:0] msg_mem [BUFFER_SIZE_DEF];
        int unsigned      base_seq;
        int unsigned      next_seq;
        int unsigned      held;
        bit               timer_on;
        int unsigned      ticks_left;
        logic [WIN_W-1:0] win_reg;
        logic [TMO_W-1:0] tmo_reg;
        gbn_packet_t      sends_due[$];
        int unsigned      mismatches;
        int unsigned      checked;

        function new();
            base_seq   = 0;
            next_seq   = 0;
            held       = 0;
            timer_on   = 1'b0;
            ticks_left = 0;
            win_reg    = WINDOW_RESET;
            tmo_reg    = TIMEOUT_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic addr, logic [CFG_W-1:0] value);
            if (addr == REG_WINDOW) win_reg = value[WIN_W-1:0];
            else tmo_reg = value[TMO_W-1:0];
        endfunction

        // 0 behaves as 1, anything past MAX_WINDOW is clamped
        function int unsigned window_span();
            if (win_reg == 0) return 1;
            if (win_reg > MAX_WINDOW) return MAX_WINDOW;
            return win_reg;
        endfunction

        function void arm_timer();
            timer_on   = 1'b1;
            ticks_left = (tmo_reg == 0) ? 1 : tmo_reg;
        endfunction

        function void queue_packet(int unsigned seq);
            gbn_packet_t      pkt;
            logic [PAY_W-1:0] body;
            bit               ended;
            int               k;
            body    = msg_mem[seq];
            pkt.seq = seq[SEQ_W-1:0];
            pkt.sum = seq[SUM_W-1:0];
            ended   = 1'b0;
            for (k = 0; k < PAYLOAD_BYTES_DEF; k++) begin
                if (body[8*k +: 8] == 8'h00) ended = 1'b1;
                if (!ended) pkt.sum += body[8*k +: 8];
            end
            pkt.lo   = body[63:0];
            pkt.mid  = body[127:64];
            pkt.hi   = body[159:128];
            pkt.last = 1'b0;
            sends_due.push_back(pkt);
        endfunction

        function void send_window();
            int unsigned limit;
            int unsigned sent;
            bit          at_base;
            limit   = base_seq + window_span();
            at_base = (base_seq == next_seq);
            sent    = 0;
            while (next_seq < held && next_seq < limit && sent < MAX_WINDOW) begin
                queue_packet(next_seq);
                sent++;
                if (at_base) arm_timer();
                next_seq++;
            end
        endfunction

        function void note_request(logic [1:0] req, logic [IN_W-1:0] data);
            int unsigned      before_cnt;
            int unsigned      seq;
            logic [ACK_W-1:0] ack;
            bit               ended;
            int               k;
            before_cnt = sends_due.size();
            case (req)
                REQ_MSG: begin
                    if (held < BUFFER_SIZE_DEF) begin
                        ended = 1'b0;
                        for (k = 0; k < PAYLOAD_BYTES_DEF; k++) begin
                            if (data[8*k +: 8] == 8'h00) ended = 1'b1;
                            msg_mem[held][8*k +: 8] = ended ? 8'h00 : data[8*k +: 8];
                        end
                        held++;
                        send_window();
                    end
                end
                REQ_ACK: begin
                    ack = data[PAY_W +: ACK_W];
                    if (!ack[ACK_W-1] && ack == base_seq && base_seq < next_seq) begin
                        base_seq++;
                        timer_on   = 1'b0;
                        ticks_left = 0;
                        if (base_seq < next_seq) arm_timer();
                        else send_window();
                    end
                end
                REQ_TICK: begin
                    if (timer_on) begin
                        if (ticks_left <= 1) begin
                            timer_on   = 1'b0;
                            ticks_left = 0;
                            for (seq = base_seq; seq < next_seq &&
                                 sends_due.size() - before_cnt < MAX_WINDOW; seq++)
                                queue_packet(seq);
                            if (sends_due.size() > before_cnt) arm_timer();
                        end else begin
                            ticks_left--;
                        end
                    end
                end
                default: ;
            endcase
            if (sends_due.size() > before_cnt) sends_due[sends_due.size()-1].last = 1'b1;
        endfunction

        // printing stops after MAX_PRINTED lines, counting does not
        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED) $display("mismatch, packet %0d: %s", checked, what);
        endtask

        task check_packet(logic [OUT_W-1:0] data, logic last);
            gbn_packet_t      want;
            logic [SEQ_W-1:0] got_seq;
            logic [SUM_W-1:0] got_sum;
            logic [63:0]      got_lo;
            logic [63:0]      got_mid;
            logic [31:0]      got_hi;
            got_seq = data[0 +: SEQ_W];
            got_sum = data[SEQ_W +: SUM_W];
            got_lo  = data[SEQ_W+SUM_W +: 64];
            got_mid = data[SEQ_W+SUM_W+64 +: 64];
            got_hi  = data[SEQ_W+SUM_W+128 +: 32];
            checked++;
            if (sends_due.size() == 0) begin
                report_mismatch($sformatf("seq %0d sent with nothing pending", got_seq));
            end else begin
                want = sends_due.pop_front();
                if (got_seq !== want.seq)
                    report_mismatch($sformatf("seq_number %0d, want %0d", got_seq, want.seq));
                if (got_sum !== want.sum)
                    report_mismatch($sformatf("packet_sum %0d, want %0d", got_sum, want.sum));
                if (got_lo !== want.lo)
                    report_mismatch($sformatf("payload_lo %h, want %h", got_lo, want.lo));
                if (got_mid !== want.mid)
                    report_mismatch($sformatf("payload_mid %h, want %h", got_mid, want.mid));
                if (got_hi !== want.hi)
                    report_mismatch($sformatf("payload_hi %h, want %h", got_hi, want.hi));
                if (last !== want.last)
                    report_mismatch($sformatf("last_of_run %b, want %b", last, want.last));
            end
        endtask
    endclass

endpackage

// File: dv/go_back_n_sender_top_tb.sv
// Self-checking bench for go_back_n_sender_top: directed and random requests,
// config changes between phases, every sent packet checked in order.
// Depends on gbn_pkg, gbn_send_tracker_pkg and the sender RTL.
module go_back_n_sender_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;
    import gbn_send_tracker_pkg::*;

    localparam int SETTLE_CYCLES = 200;   // longer than the slowest item, a full window of sends included
    localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake at all
    localparam int PHASE_ITEMS   = 85;
    localparam int NUM_PHASES    = 6;
    localparam int PAD_W         = IN_W - PAY_W - ACK_W;

    typedef enum {IDLE_TX_LIGHT, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic [1:0]        s_tuser   = REQ_MSG;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_addr  = REG_WINDOW;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_idle_pct = 0;
    gbn_send_tracker   tracker;

    // per-phase settings; extremes plus the out-of-range window/timeout values
    int unsigned phase_win [NUM_PHASES] = '{0, 64, 127, 1, 5, 64};
    int unsigned phase_tmo [NUM_PHASES] = '{0, 3, 65535, 1, 2, 4};

    go_back_n_sender_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver: random backpressure, rate set by the current idle mode.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Every packet taken off the result channel is checked against the
    // oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_packet(m_tdata, m_tlast);
    end

    // Watchdog: a hang on either side shows up as a long run with no handshake.
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_TX_LIGHT: begin
                tx_idle_pct = 17;
                rx_idle_pct = 61;
            end
            IDLE_TX_HEAVY: begin
                tx_idle_pct = 61;
                rx_idle_pct = 17;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    // Random message bytes; half the time one byte is forced to zero so the
    // truncation point lands anywhere in the 20 bytes.
    function automatic logic [PAY_W-1:0] random_payload();
        logic [PAY_W-1:0] p;
        int               k;
        for (k = 0; k < PAYLOAD_BYTES_DEF; k++) p[8*k +: 8] = $urandom_range(255);
        if ($urandom_range(1)) p[8*$urandom_range(PAYLOAD_BYTES_DEF-1) +: 8] = 8'h00;
        return p;
    endfunction

    // All bytes set to fill except a zero at byte zero_at (none if past the end).
    function automatic logic [PAY_W-1:0] gapped_payload(logic [7:0] fill, int zero_at);
        logic [PAY_W-1:0] p;
        p = {PAYLOAD_BYTES_DEF{fill}};
        if (zero_at < PAYLOAD_BYTES_DEF) p[8*zero_at +: 8] = 8'h00;
        return p;
    endfunction

    // One item on the input channel. valid stays high into the next item
    // unless the bench idles, so back-to-back items never toggle it.
    // The prediction is updated here, in the same process, so the next
    // stimulus decision always sees the state after this item.
    task automatic drive_request(logic [1:0] req, logic [IN_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(req, data);
    endtask

    task automatic send_message(logic [PAY_W-1:0] payload);
        drive_request(REQ_MSG, {{PAD_W{1'b0}}, ACK_W'($urandom), payload});
    endtask

    task automatic send_ack(logic [ACK_W-1:0] ack);
        drive_request(REQ_ACK, {{PAD_W{1'b0}}, ack, random_payload()});
    endtask

    // tick or undecoded code; the other fields are noise
    task automatic send_plain(logic [1:0] req);
        drive_request(req, {{PAD_W{1'b0}}, ACK_W'($urandom), random_payload()});
    endtask

    // Drop valid and wait until every predicted packet is out, then let
    // extra cycles pass for an item that is still busy with no output.
    task automatic settle(int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.sends_due.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    // Both registers, window first, then timeout; only called while idle.
    task automatic configure(logic [WIN_W-1:0] win, logic [TMO_W-1:0] tmo);
        tracker.set_reg(REG_WINDOW, CFG_W'(win));
        tracker.set_reg(REG_TIMEOUT, tmo);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_WINDOW;
        cfg_wdata <= CFG_W'(win);
        @(posedge aclk);
        cfg_addr  <= REG_TIMEOUT;
        cfg_wdata <= tmo;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int               phase;
        int               n;
        int unsigned      pick;
        logic [ACK_W-1:0] ack;

        tracker = new();
        set_idle(IDLE_TX_LIGHT);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed: narrow window of 3, 2-tick timeout ----
        configure(7'd3, 16'd2);
        send_message(gapped_payload(8'hFF, PAYLOAD_BYTES_DEF));  // largest checksum, timer start
        send_message(gapped_payload(8'hA5, 0));                  // empty after truncation
        send_message(gapped_payload(8'h5A, 7));                  // zero mid-message
        send_message(gapped_payload(8'h81, 19));                 // window full: stored only
        send_ack('1);                                            // -1: nothing yet
        send_ack(ACK_W'(1));                                     // not the base
        send_ack(ACK_W'(0));                                     // slides, others outstanding
        send_plain(REQ_TICK);
        send_plain(REQ_TICK);                                    // expiry: resend 1..2
        drive_request(REQ_UNUSED, '1);                           // undecoded request
        send_ack(ACK_W'(1));
        send_ack(ACK_W'(2));                                     // window empties: 3 goes out
        send_ack(ACK_W'(3));                                     // nothing left, timer stops
        send_plain(REQ_TICK);                                    // timer idle
        send_ack(ACK_W'(4));                                     // base == next: ignored
        send_ack(ACK_W'(1023));                                  // largest positive ack
        drive_request(REQ_MSG, '1);
        settle(SETTLE_CYCLES);

        // ---- random phases: mostly well-formed traffic, some noise ----
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            set_idle(idle_mode_t'(phase / 2));
            configure(WIN_W'(phase_win[phase]), TMO_W'(phase_tmo[phase]));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // occasionally hold off until the block has drained
                if ($urandom_range(99) < 3) settle(0);
                pick = $urandom_range(99);
                if (pick < 40) begin
                    send_message(random_payload());
                end else if (pick < 75) begin
                    // mostly the ack the block is waiting for
                    case ($urandom_range(9))
                        7:       ack = ACK_W'(tracker.base_seq + ($urandom_range(1) ? 1 : -1));
                        8:       ack = '1;
                        9:       ack = ACK_W'($urandom);
                        default: ack = ACK_W'(tracker.base_seq);
                    endcase
                    send_ack(ack);
                end else if (pick < 95) begin
                    send_plain(REQ_TICK);
                end else begin
                    send_plain(REQ_UNUSED);
                end
            end
            settle(SETTLE_CYCLES);
        end

        if (tracker.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
